/* hdl/sha256_pkg.sv */
// Package: SHA-256 constants, request type and round functions.
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] data;
  } req_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

/* hdl/sha256_queue.sv */
// Small request FIFO between the input side and the hashing engine.
module sha256_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  sha256_pkg::req_t    wr_req,
  output logic                rd_valid,
  input  logic                rd_ready,
  output sha256_pkg::req_t    rd_req
);
  import sha256_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t              mem [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_req   = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !rd_valid)
    else $error("valid while empty");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("count did not advance on push");

endmodule

/* hdl/sha256_engine.sv */
// Hashing engine: buffers bytes, pads, runs 64 rounds and emits the digest.
module sha256_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  sha256_pkg::req_t    req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t       state_r;
  logic [31:0]  buf_r [16];  // block as big-endian words, byte writes
  logic [5:0]   fill_r;
  logic [5:0]   idx_r;
  logic [63:0]  bits_r;
  logic [63:0]  total_r;
  logic         fin_r;       // current block belongs to a finish
  logic         extra_r;     // a second (length) block follows
  logic [31:0]  h_r [8];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [31:0]  w_r [16];
  logic [2:0]   oi_r;

  logic [31:0]  wt, wn, t1, t2, ch, mj;
  logic [5:0]   t;

  assign t = idx_r;
  // schedule: window holds w[t..t+15]
  assign wn = sig1(w_r[14]) + w_r[9] + sig0(w_r[1]) + w_r[0];
  assign wt = w_r[0];
  assign ch = (e_r & f_r) ^ (~e_r & g_r);
  assign mj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
  assign t1 = hh_r + bsig1(e_r) + ch + K[t] + wt;
  assign t2 = bsig0(a_r) + mj;

  assign req_ready       = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_EMIT);
  assign out_digest_word = h_r[oi_r];
  assign out_word_index  = oi_r;
  assign out_last_word   = (oi_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      idx_r   <= '0;
      oi_r    <= '0;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            if (req.op == OP_ABSORB) begin
              buf_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= req.data;
              fill_r        <= fill_r + 1'b1;
              if (fill_r == 6'd63) begin
                fin_r   <= 1'b0;
                idx_r   <= '0;
                bits_r  <= bits_r + 64'd512;
                state_r <= S_LOAD;
              end
            end else begin
              total_r <= bits_r + {55'd0, fill_r, 3'd0};
              buf_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= 8'h80;
              extra_r <= (fill_r >= 6'd56);
              fin_r   <= 1'b1;
              // wraps to zero when the marker filled the block
              idx_r   <= fill_r + 1'b1;
              state_r <= (fill_r == 6'd63) ? S_LOAD : S_PAD;
            end
          end
        end
        S_PAD: begin
          // zero fill, then length bytes unless another block follows
          if (!extra_r && idx_r >= 6'd56) begin
            buf_r[idx_r[5:2]][8*(3-idx_r[1:0]) +: 8] <= total_r[8*(7-idx_r[2:0]) +: 8];
          end else begin
            buf_r[idx_r[5:2]][8*(3-idx_r[1:0]) +: 8] <= 8'h00;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == 6'd63) state_r <= S_LOAD;
        end
        S_LOAD: begin
          // load message words into the schedule window, init working vars
          for (int i = 0; i < 16; i++) begin
            w_r[i] <= buf_r[i];
          end
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          e_r <= h_r[4]; f_r <= h_r[5]; g_r <= h_r[6]; hh_r <= h_r[7];
          idx_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
          d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
          idx_r <= idx_r + 1'b1;
          if (idx_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r; h_r[5] <= h_r[5] + f_r;
          h_r[6] <= h_r[6] + g_r; h_r[7] <= h_r[7] + hh_r;
          idx_r <= '0;
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (extra_r) begin
            extra_r <= 1'b0;
            state_r <= S_PAD;
          end else begin
            oi_r    <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            oi_r <= oi_r + 1'b1;
            if (oi_r == 3'd7) begin
              fin_r   <= 1'b0;
              fill_r  <= '0;
              bits_r  <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= IV[i];
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> fin_r)
    else $error("digest emitted without finish");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(oi_r)))
    else $error("digest word dropped");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (state_r == S_IDLE && fill_r == '0))
    else $error("no restart after digest");

endmodule

/* hdl/sha256_message_hasher.sv */
// Top level: SHA-256 byte-stream hasher, request queue plus hashing engine.
//
// channel   direction  payload
// in_       input      in_opcode, in_data_byte
// out_      output     out_digest_word, out_word_index, out_last_word
//
// Each absorb request writes one byte into the engine's block buffer; every 64th
// byte runs a block of load, 64 rounds and fold while the engine takes no request.
// Finish pads one byte per cycle, runs one or two blocks, then emits 8 words.
// Reset (rst_n low, synchronous) loads the initial hash and empties the queue.
// A stalled output holds the engine; the queue keeps taking requests until full.
module sha256_message_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha256_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req.op   = opcode_t'(in_opcode);
  assign in_req.data = in_data_byte;

  sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_req(in_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_req(q_req)
  );

  sha256_engine u_engine (
    .clk, .rst_n,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule
